// ===== rtl/bskl_pkg.sv =====
package bskl_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned OUT_W   = 5;
	localparam int unsigned CAP_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	// Read address sources: scan index, entry below the shift pointer,
	// entry above the shift pointer, requested position.
	typedef enum logic [1:0] {
		RA_IDX   = 2'd0,
		RA_BELOW = 2'd1,
		RA_ABOVE = 2'd2,
		RA_POS   = 2'd3
	} raddr_sel_t;

	typedef struct packed {
		logic       load_item;
		logic       rd_en;
		raddr_sel_t raddr_sel;
		logic       wr_en;
		logic       wr_key;
		logic       idx_clr;
		logic       idx_inc;
		logic       idx_to_count;
		logic       j_from_count;
		logic       j_from_idx;
		logic       j_dec;
		logic       j_inc;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		status_t    res_status;
	} bskl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic count_zero;
		logic full;
		logic idx_last;
		logic key_less;
		logic key_equal;
		logic j_above_slot;
		logic j_next_below_count;
		logic pos_ok;
	} bskl_stat_t;

endpackage

// ===== rtl/bskl_if.sv =====
interface bskl_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] key_value;
	logic [3:0]         position;

	modport source (output valid, output operation, output key_value, output position,
		input ready);
	modport sink (input valid, input operation, input key_value, input position,
		output ready);
endinterface

interface bskl_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [4:0]         found_index;
	logic signed [31:0] read_value;
	logic [4:0]         key_count;

	modport source (output valid, output status, output found_index, output read_value,
		output key_count, input ready);
	modport sink (input valid, input status, input found_index, input read_value,
		input key_count, output ready);
endinterface

// ===== rtl/bskl_dp.sv =====
module bskl_dp
	import bskl_pkg::*;
#(
	parameter int unsigned MAX_KEYS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CAP_W-1:0]          cfg_wdata,
	input  logic [1:0]                in_operation,
	input  logic signed [KEY_W-1:0]   in_key_value,
	input  logic [3:0]                in_position,
	input  bskl_cmd_t                 cmd,
	output bskl_stat_t                stat,
	output logic [2:0]                res_status,
	output logic [OUT_W-1:0]          res_found_index,
	output logic signed [KEY_W-1:0]   res_read_value,
	output logic [OUT_W-1:0]          res_key_count
);

	localparam int unsigned IDX_W = $clog2(MAX_KEYS);
	localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);

	logic signed [KEY_W-1:0] mem [MAX_KEYS];
	logic signed [KEY_W-1:0] rdata_q;
	logic signed [KEY_W-1:0] key_q;
	op_t                     op_q;
	logic [3:0]              pos_q;
	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        j_q;

	logic [IDX_W-1:0]        raddr;
	logic [IDX_W-1:0]        waddr;
	logic signed [KEY_W-1:0] wdata;
	logic [CNT_W-1:0]        found_sel;
	logic signed [KEY_W-1:0] read_sel;

	always_comb begin
		case (cmd.raddr_sel)
			RA_IDX:   raddr = IDX_W'(idx_q);
			RA_BELOW: raddr = IDX_W'(j_q - 1'b1);
			RA_ABOVE: raddr = IDX_W'(j_q + 1'b1);
			RA_POS:   raddr = IDX_W'(pos_q);
			default:  raddr = IDX_W'(idx_q);
		endcase
		waddr = cmd.wr_key ? IDX_W'(idx_q) : IDX_W'(j_q);
		wdata = cmd.wr_key ? key_q : rdata_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q <= in_key_value;
			pos_q <= in_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			op_q    <= OP_INSERT;
			idx_q   <= '0;
			j_q     <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.load_item) begin
				op_q <= op_t'(in_operation);
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_to_count) begin
				idx_q <= count_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.j_from_count) begin
				j_q <= count_q;
			end else if (cmd.j_from_idx) begin
				j_q <= idx_q;
			end else if (cmd.j_dec) begin
				j_q <= j_q - 1'b1;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_comb begin
		stat.op                 = op_q;
		stat.count_zero         = (count_q == '0);
		stat.full               = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= MAX_KEYS);
		stat.idx_last           = (32'(idx_q) + 32'd1) >= 32'(count_q);
		stat.key_less           = (rdata_q < key_q);
		stat.key_equal          = (rdata_q == key_q);
		stat.j_above_slot       = (j_q > idx_q);
		stat.j_next_below_count = (32'(j_q) + 32'd1) < 32'(count_q);
		stat.pos_ok             = 32'(pos_q) < 32'(count_q);
	end

	always_comb begin
		if (op_q == OP_FIND) begin
			found_sel = (cmd.res_status == ST_OK) ? idx_q : count_q;
		end else begin
			found_sel = '0;
		end
		if (op_q == OP_READ && cmd.res_status == ST_OK) begin
			read_sel = rdata_q;
		end else begin
			read_sel = '0;
		end
	end

	// Counts wider than the result fields wrap, as they would on a 5-bit bus.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status      <= cmd.res_status;
			res_found_index <= OUT_W'(found_sel);
			res_read_value  <= read_sel;
			res_key_count   <= OUT_W'(count_q);
		end
	end

endmodule

// ===== rtl/bskl_ctrl.sv =====
module bskl_ctrl
	import bskl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  bskl_stat_t stat,
	output bskl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_INS_CHK,
		S_INS_WR,
		S_DEL_CHK,
		S_DEL_WR,
		S_FIN
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t status_q;
	status_t fin_status;
	logic    go_fin;
	logic    out_valid_q;
	logic    slot_free;
	logic    hit;
	logic    miss;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.raddr_sel  = RA_IDX;
		cmd.res_status = status_q;
		state_d        = state_q;
		go_fin         = 1'b0;
		fin_status     = ST_OK;
		// The scan stops at the first entry not below the key, or past the end.
		hit  = !stat.key_less && stat.key_equal;
		miss = stat.key_less ? stat.idx_last : !stat.key_equal;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.idx_clr = 1'b1;
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							go_fin     = 1'b1;
							fin_status = ST_FULL;
						end else if (stat.count_zero) begin
							cmd.j_from_count = 1'b1;
							state_d          = S_INS_CHK;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					OP_DELETE: begin
						if (stat.count_zero) begin
							go_fin     = 1'b1;
							fin_status = ST_RANGE;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					OP_FIND: begin
						if (stat.count_zero) begin
							go_fin     = 1'b1;
							fin_status = ST_MISSING;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					OP_READ: begin
						go_fin = 1'b1;
						if (stat.pos_ok) begin
							cmd.rd_en     = 1'b1;
							cmd.raddr_sel = RA_POS;
							fin_status    = ST_OK;
						end else begin
							fin_status = ST_RANGE;
						end
					end
					default: begin
						go_fin     = 1'b1;
						fin_status = ST_RANGE;
					end
				endcase
			end
			S_SCAN_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.raddr_sel = RA_IDX;
				state_d       = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (stat.key_less && !stat.idx_last) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end else begin
					if (stat.key_less) begin
						cmd.idx_to_count = 1'b1;
					end
					case (stat.op)
						OP_INSERT: begin
							if (hit) begin
								go_fin     = 1'b1;
								fin_status = ST_DUP;
							end else begin
								cmd.j_from_count = 1'b1;
								state_d          = S_INS_CHK;
							end
						end
						OP_DELETE: begin
							if (miss) begin
								go_fin     = 1'b1;
								fin_status = ST_MISSING;
							end else begin
								cmd.j_from_idx = 1'b1;
								state_d        = S_DEL_CHK;
							end
						end
						default: begin
							go_fin     = 1'b1;
							fin_status = hit ? ST_OK : ST_MISSING;
						end
					endcase
				end
			end
			S_INS_CHK: begin
				if (stat.j_above_slot) begin
					cmd.rd_en     = 1'b1;
					cmd.raddr_sel = RA_BELOW;
					state_d       = S_INS_WR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_key  = 1'b1;
					cmd.cnt_inc = 1'b1;
					go_fin      = 1'b1;
					fin_status  = ST_OK;
				end
			end
			S_INS_WR: begin
				cmd.wr_en = 1'b1;
				cmd.j_dec = 1'b1;
				state_d   = S_INS_CHK;
			end
			S_DEL_CHK: begin
				if (stat.j_next_below_count) begin
					cmd.rd_en     = 1'b1;
					cmd.raddr_sel = RA_ABOVE;
					state_d       = S_DEL_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					go_fin      = 1'b1;
					fin_status  = ST_OK;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en = 1'b1;
				cmd.j_inc = 1'b1;
				state_d   = S_DEL_CHK;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (go_fin) begin
			state_d = S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go_fin) begin
				status_q <= fin_status;
			end
			if (state_q == S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/bounded_sorted_key_list.sv =====
// A read passes through the dispatch and finish states only; insert, delete and
// find also scan the held keys, and insert and delete then shift entries.
// The block takes one item at a time; the key memory has one read port, and each
// scanned or shifted entry takes a read state and then a compare or write state.
// Reset clears the key count, the handshakes and sets capacity to 16; the key
// memory is not cleared, and only entries below the count are ever read.
module bounded_sorted_key_list
	import bskl_pkg::*;
#(
	parameter int unsigned MAX_KEYS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	bskl_in_if.sink          req,
	bskl_out_if.source       rsp
);

	bskl_cmd_t  cmd;
	bskl_stat_t stat;
	logic       in_ready;
	logic       out_valid;

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	bskl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bskl_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_operation    (req.operation),
		.in_key_value    (req.key_value),
		.in_position     (req.position),
		.cmd             (cmd),
		.stat            (stat),
		.res_status      (rsp.status),
		.res_found_index (rsp.found_index),
		.res_read_value  (rsp.read_value),
		.res_key_count   (rsp.key_count)
	);

endmodule
